// File: hdl/atqet_pkg.sv
// ----------------------------------------------------------------------------
// atqet_pkg : shared types and constants of the quoted entry tokeniser
// Holds the channel payload types, the lexer state record, the keyword
// table and the small helper functions used by the lexer.
// ----------------------------------------------------------------------------
package atqet_pkg;

   localparam int RSP_DEPTH  = 4;
   localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);
   localparam int KW_COUNT   = 3;

   localparam logic [15:0] MAX_LEN_RESET = 16'd32000;

   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // keywords desc, log and text; unused tail slots hold zero
   localparam logic [7:0] KW_TEXT [KW_COUNT][4] = '{
      '{8'h64, 8'h65, 8'h73, 8'h63},
      '{8'h6C, 8'h6F, 8'h67, 8'h00},
      '{8'h74, 8'h65, 8'h78, 8'h74}
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd3, 3'd4};

   typedef enum logic [2:0] {
      PH_OUTSIDE = 3'b001,
      PH_STRING  = 3'b010,
      PH_AT_SEEN = 3'b100
   } phase_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       end_of_entry;
      logic       too_long;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } lex_out_type;

   typedef struct packed {
      phase_type            phase;
      logic                 last_was_space;
      logic                 first_word_done;
      logic                 ends_with_string;
      logic [15:0]          entry_length;
      logic                 first_char_digit;
      logic [KW_COUNT-1:0]  kw_match;
      logic [2:0]           kw_pos;
   } lex_state_type;

   localparam lex_state_type CLEAR_STATE = '{
      phase:            PH_OUTSIDE,
      last_was_space:   1'b1,
      first_word_done:  1'b0,
      ends_with_string: 1'b0,
      entry_length:     16'd0,
      first_char_digit: 1'b0,
      kw_match:         {KW_COUNT{1'b1}},
      kw_pos:           3'd0
   };

   localparam rsp_type END_MARK =
      '{out_byte: 8'h00, has_byte: 1'b0, end_of_entry: 1'b1, too_long: 1'b0};
   localparam rsp_type TOO_LONG_MARK =
      '{out_byte: 8'h00, has_byte: 1'b0, end_of_entry: 1'b1, too_long: 1'b1};

   function automatic rsp_type byte_rsp(input logic [7:0] b);
      rsp_type r;
      r = '{out_byte: b, has_byte: 1'b1, end_of_entry: 1'b0, too_long: 1'b0};
      return r;
   endfunction

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b inside {[CH_ZERO:CH_NINE]};
   endfunction

   // account for one byte appended to the entry
   function automatic lex_state_type track_byte(input lex_state_type s,
                                                input logic [7:0] b);
      lex_state_type t;
      t = s;
      if (!t.first_word_done) begin
         if (t.entry_length == 16'd0) begin
            t.first_char_digit = is_digit(b);
         end
         for (int k = 0; k < KW_COUNT; k++) begin
            if (t.kw_match[k] &&
                ((t.kw_pos >= KW_LEN[k]) || (KW_TEXT[k][t.kw_pos[1:0]] != b))) begin
               t.kw_match[k] = 1'b0;
            end
         end
         if (t.kw_pos != 3'd7) begin
            t.kw_pos = t.kw_pos + 3'd1;
         end
      end
      t.entry_length = sat_inc(t.entry_length);
      return t;
   endfunction

endpackage

// File: hdl/atqet_if.sv
// ----------------------------------------------------------------------------
// atqet_if : channel interfaces of the quoted entry tokeniser
// Request, response and register write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface atqet_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface atqet_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       end_of_entry;
   logic       too_long;

   modport source (output valid, output out_byte, output has_byte,
                   output end_of_entry, output too_long, input ready);
   modport sink   (input valid, input out_byte, input has_byte,
                   input end_of_entry, input too_long, output ready);
endinterface

interface atqet_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] wdata;

   modport source (output valid, output wdata, input ready);
   modport sink   (input valid, input wdata, output ready);
endinterface

// File: hdl/at_quoted_entry_tokenizer_core.sv
// ----------------------------------------------------------------------------
// at_quoted_entry_tokenizer_core : archive entry tokeniser
// Splits an archive byte stream into entries of kept bytes, each closed by
// an end marker word, with whitespace collapsing, '@' strings, keyword and
// numeric entry endings and a length limit.
//
//   channel  dir  words carry                                   handshake
//   req_if   in   mode, data_byte                               valid/ready
//   rsp_if   out  out_byte, has_byte, end_of_entry, too_long    valid/ready
//   csr_if   in   wdata = max_entry_length                      valid/ready
//
// One request word per cycle is taken while the queue has room; a word
// lands in the input register, passes the lexer logic and is written as
// zero, one or two result words into a four-deep result queue; a result
// passes the input register and then the queue register before it leaves.
// The queue releases one word per cycle while the receiver is ready. The
// input stalls only while the queue holds more than two words. Reset is
// synchronous; no clearing pass follows.
// ----------------------------------------------------------------------------
module at_quoted_entry_tokenizer_core (
   input  logic              clock,
   input  logic              reset,
   atqet_req_if.sink         req_if,
   atqet_rsp_if.source       rsp_if,
   atqet_csr_if.sink         csr_if
);

   // input register
   logic                           in_valid_ff;
   logic                           in_valid_in;
   atqet_pkg::req_type             in_ff;
   logic                           req_take;

   // length limit register
   logic [15:0]                    max_len_ff;

   // lexer and result queue
   atqet_pkg::lex_out_type         lex_out;
   logic                           fire;
   logic [1:0]                     push_n;
   logic                           pop;
   atqet_pkg::rsp_type             head;
   logic [atqet_pkg::RSP_CNT_W-1:0] q_count;
   logic                           q_room;

   // advance the held word when the queue has room for two results
   assign fire          = in_valid_ff & q_room;
   assign req_if.ready  = ~in_valid_ff | q_room;
   assign req_take      = req_if.valid & req_if.ready;
   assign in_valid_in   = req_take | (in_valid_ff & ~fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold the payload until a new word is taken
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff.mode      <= req_if.mode;
         in_ff.data_byte <= req_if.data_byte;
      end
   end

   // register writes are always taken
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= atqet_pkg::MAX_LEN_RESET;
      end else if (csr_if.valid) begin
         max_len_ff <= csr_if.wdata;
      end
   end

   atqet_lexer u_lexer (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (in_ff),
      .max_len (max_len_ff),
      .lex_out (lex_out)
   );

   // drop the results of a word that is not advancing
   assign push_n = fire ? lex_out.count : 2'd0;
   assign pop    = rsp_if.valid & rsp_if.ready;

   atqet_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_n      (push_n),
      .push_first  (lex_out.first),
      .push_second (lex_out.second),
      .pop         (pop),
      .head        (head),
      .count       (q_count),
      .room        (q_room)
   );

   assign rsp_if.valid        = (q_count != '0);
   assign rsp_if.out_byte     = head.out_byte;
   assign rsp_if.has_byte     = head.has_byte;
   assign rsp_if.end_of_entry = head.end_of_entry;
   assign rsp_if.too_long     = head.too_long;

   // two results only arise when a closing '@' ends a keyword entry
   a_pair_starts_with_end: assert property (@(posedge clock) disable iff (reset)
      (fire && (lex_out.count == 2'd2)) |-> lex_out.first.end_of_entry)
      else $error("two results without a leading end marker");

   // the queue never holds more than its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= atqet_pkg::RSP_CNT_W'(atqet_pkg::RSP_DEPTH))
      else $error("result queue overflow");

   // an end marker never carries a byte, and too_long only comes with it
   a_marker_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (!(rsp_if.has_byte && rsp_if.end_of_entry) &&
                        (!rsp_if.too_long || rsp_if.end_of_entry)))
      else $error("malformed result word");

   // a held word that does not advance keeps the input register occupied
   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> in_valid_ff)
      else $error("held request word lost");

endmodule

// File: hdl/atqet_lexer.sv
// ----------------------------------------------------------------------------
// atqet_lexer : per-word entry lexer
// Holds the entry state and turns one registered input word into up to two
// result words in a single pass of logic.
// ----------------------------------------------------------------------------
module atqet_lexer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  atqet_pkg::req_type    item,
   input  logic [15:0]           max_len,
   output atqet_pkg::lex_out_type lex_out
);

   atqet_pkg::lex_state_type st_ff;
   atqet_pkg::lex_state_type st_in;
   atqet_pkg::rsp_type       r0;
   atqet_pkg::rsp_type       r_out;
   logic                     has_out;
   logic                     run_outside;
   logic [1:0]               n;
   logic [7:0]               b;

   always_comb begin
      st_in       = st_ff;
      b           = item.data_byte;
      n           = 2'd0;
      r0          = '0;
      r_out       = '0;
      has_out     = 1'b0;
      run_outside = 1'b0;

      if (item.mode) begin
         st_in = atqet_pkg::CLEAR_STATE;
         r0    = atqet_pkg::END_MARK;
         n     = 2'd1;
      end else begin
         case (st_ff.phase)
            atqet_pkg::PH_STRING: begin
               if (b == atqet_pkg::CH_AT) begin
                  st_in       = atqet_pkg::track_byte(st_in, b);
                  st_in.phase = atqet_pkg::PH_AT_SEEN;
                  r0          = atqet_pkg::byte_rsp(b);
               end else if (atqet_pkg::sat_inc(st_ff.entry_length) > max_len) begin
                  st_in = atqet_pkg::CLEAR_STATE;
                  r0    = atqet_pkg::TOO_LONG_MARK;
               end else begin
                  st_in = atqet_pkg::track_byte(st_in, b);
                  r0    = atqet_pkg::byte_rsp(b);
               end
               n = 2'd1;
            end
            atqet_pkg::PH_AT_SEEN: begin
               if (b == atqet_pkg::CH_AT) begin
                  st_in       = atqet_pkg::track_byte(st_in, b);
                  st_in.phase = atqet_pkg::PH_STRING;
                  r0          = atqet_pkg::byte_rsp(b);
                  n           = 2'd1;
               end else begin
                  // string closed; a keyword entry ends here
                  st_in.phase = atqet_pkg::PH_OUTSIDE;
                  run_outside = 1'b1;
                  if (st_ff.ends_with_string) begin
                     st_in = atqet_pkg::CLEAR_STATE;
                     r0    = atqet_pkg::END_MARK;
                     n     = 2'd1;
                  end
               end
            end
            default: begin
               st_in.phase = atqet_pkg::PH_OUTSIDE;
               run_outside = 1'b1;
            end
         endcase
      end

      if (run_outside) begin
         if (atqet_pkg::is_space(b)) begin
            if (!st_in.last_was_space) begin
               st_in.last_was_space = 1'b1;
               if (st_in.entry_length != 16'd0) begin
                  if (!st_in.first_word_done && st_in.first_char_digit) begin
                     st_in   = atqet_pkg::CLEAR_STATE;
                     r_out   = atqet_pkg::END_MARK;
                     has_out = 1'b1;
                  end else begin
                     if (!st_in.first_word_done) begin
                        for (int k = 0; k < atqet_pkg::KW_COUNT; k++) begin
                           if (st_in.kw_match[k] && (st_in.kw_pos == atqet_pkg::KW_LEN[k])) begin
                              st_in.ends_with_string = 1'b1;
                           end
                        end
                        st_in.first_word_done = 1'b1;
                     end
                     st_in   = atqet_pkg::track_byte(st_in, atqet_pkg::CH_SPACE);
                     r_out   = atqet_pkg::byte_rsp(atqet_pkg::CH_SPACE);
                     has_out = 1'b1;
                  end
               end
            end
         end else if (b == atqet_pkg::CH_SEMI) begin
            st_in   = atqet_pkg::CLEAR_STATE;
            r_out   = atqet_pkg::END_MARK;
            has_out = 1'b1;
         end else begin
            st_in.last_was_space = 1'b0;
            st_in                = atqet_pkg::track_byte(st_in, b);
            if (b == atqet_pkg::CH_AT) begin
               st_in.phase = atqet_pkg::PH_STRING;
            end
            r_out   = atqet_pkg::byte_rsp(b);
            has_out = 1'b1;
         end
      end

      lex_out.count  = n + {1'b0, has_out};
      lex_out.first  = (n == 2'd0) ? r_out : r0;
      lex_out.second = r_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= atqet_pkg::CLEAR_STATE;
      end else if (fire) begin
         st_ff <= st_in;
      end
   end

endmodule

// File: hdl/atqet_rsp_fifo.sv
// ----------------------------------------------------------------------------
// atqet_rsp_fifo : result queue
// Takes up to two result words per cycle and releases one per handshake.
// ----------------------------------------------------------------------------
module atqet_rsp_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [1:0]                          push_n,
   input  atqet_pkg::rsp_type                  push_first,
   input  atqet_pkg::rsp_type                  push_second,
   input  logic                                pop,
   output atqet_pkg::rsp_type                  head,
   output logic [atqet_pkg::RSP_CNT_W-1:0]     count,
   output logic                                room
);

   atqet_pkg::rsp_type                   mem_ff [atqet_pkg::RSP_DEPTH];
   logic [atqet_pkg::RSP_PTR_W-1:0]      wr_ptr_ff;
   logic [atqet_pkg::RSP_PTR_W-1:0]      wr_ptr_in;
   logic [atqet_pkg::RSP_PTR_W-1:0]      rd_ptr_ff;
   logic [atqet_pkg::RSP_PTR_W-1:0]      rd_ptr_in;
   logic [atqet_pkg::RSP_CNT_W-1:0]      count_ff;
   logic [atqet_pkg::RSP_CNT_W-1:0]      count_in;

   localparam logic [atqet_pkg::RSP_CNT_W-1:0] ROOM_LIMIT =
      atqet_pkg::RSP_CNT_W'(atqet_pkg::RSP_DEPTH - 2);

   assign wr_ptr_in = wr_ptr_ff + atqet_pkg::RSP_PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + atqet_pkg::RSP_PTR_W'(pop);
   assign count_in  = count_ff + atqet_pkg::RSP_CNT_W'(push_n)
                    - atqet_pkg::RSP_CNT_W'(pop);

   assign head  = mem_ff[rd_ptr_ff];
   assign count = count_ff;
   assign room  = (count_ff <= ROOM_LIMIT);

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_first;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ptr_ff + atqet_pkg::RSP_PTR_W'(1)] <= push_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: verif/at_quoted_entry_tokenizer_core_tb.sv
// ----------------------------------------------------------------------------
// at_quoted_entry_tokenizer_core_tb : self-checking bench for the tokeniser
// Feeds archive bytes and end-of-input words into the tokeniser. An in-bench
// model of the lexer predicts every entry byte and end marker, and each
// result word is compared with the oldest prediction. Both channels idle at
// random. The result side holds off once for a long stretch. The length
// limit moves between phases, and the phases span from 1 up to 65534.
// ----------------------------------------------------------------------------
module at_quoted_entry_tokenizer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // request mode codes
   localparam logic MODE_DATA = 1'b0;
   localparam logic MODE_EOF  = 1'b1;

   // keyword slots: desc, log, text
   localparam int KEY_DESC = 0;
   localparam int KEY_LOG  = 1;
   localparam int KEY_TEXT = 2;

   localparam int RESET_CYCLES   = 6;
   localparam int DRAIN_CYCLES   = 6;     // input register plus queue slack
   localparam int RX_HOLD_CYCLES = 300;   // long hold-off on the result side
   localparam int STALL_LIMIT    = 2000;  // cycles with no handshake at all
   localparam int MAX_REPORTS    = 100;

   // -------------------------------------------------------------------------
   // Entry predictor and store of expected result words
   // -------------------------------------------------------------------------
   class tokenizer_scoreboard;
      atqet_pkg::phase_type                str_phase;
      bit                                  space_seen;
      bit                                  head_done;
      bit                                  closes_on_string;
      logic [15:0]                         length;
      bit                                  leads_digit;
      logic [atqet_pkg::KW_COUNT-1:0]      kw_alive;
      logic [2:0]                          kw_idx;
      logic [15:0]                         limit;
      atqet_pkg::rsp_type                  expected_words[$];
      int unsigned                         mismatches;
      int unsigned                         words_seen;

      function new();
         limit      = atqet_pkg::MAX_LEN_RESET;
         mismatches = 0;
         words_seen = 0;
         restart_entry();
      endfunction

      function void restart_entry();
         str_phase        = atqet_pkg::PH_OUTSIDE;
         space_seen       = 1'b1;
         head_done        = 1'b0;
         closes_on_string = 1'b0;
         length           = 16'd0;
         leads_digit      = 1'b0;
         kw_alive         = '1;
         kw_idx           = 3'd0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function logic [15:0] bump(logic [15:0] v);
         return (v == 16'hFFFF) ? v : v + 16'd1;
      endfunction

      function logic [7:0] keyword_char(int k, int pos);
         logic [31:0] spelled;
         case (k)
            KEY_DESC: spelled = "desc";
            KEY_LOG:  spelled = {"log", 8'h00};
            default:  spelled = "text";
         endcase
         return spelled[8*(3-pos) +: 8];
      endfunction

      function int keyword_len(int k);
         return (k == KEY_LOG) ? 3 : 4;
      endfunction

      function void expect_word(atqet_pkg::rsp_type w);
         expected_words.push_back(w);
      endfunction

      function atqet_pkg::rsp_type byte_word(logic [7:0] b);
         atqet_pkg::rsp_type w;
         w.out_byte     = b;
         w.has_byte     = 1'b1;
         w.end_of_entry = 1'b0;
         w.too_long     = 1'b0;
         return w;
      endfunction

      // account for one byte appended to the entry
      function void absorb_byte(logic [7:0] b);
         if (!head_done) begin
            if (length == 16'd0) begin
               leads_digit = (b >= atqet_pkg::CH_ZERO) && (b <= atqet_pkg::CH_NINE);
            end
            for (int k = 0; k < atqet_pkg::KW_COUNT; k++) begin
               if (kw_alive[k] && ((int'(kw_idx) >= keyword_len(k)) ||
                   (keyword_char(k, int'(kw_idx[1:0])) != b))) begin
                  kw_alive[k] = 1'b0;
               end
            end
            if (kw_idx != 3'd7) begin
               kw_idx = kw_idx + 3'd1;
            end
         end
         length = bump(length);
      endfunction

      // byte seen outside any string
      function void lex_plain(logic [7:0] b);
         if ((b == atqet_pkg::CH_SPACE) || (b == atqet_pkg::CH_TAB) ||
             (b == atqet_pkg::CH_CR) || (b == atqet_pkg::CH_LF)) begin
            if (space_seen) begin
               return;
            end
            space_seen = 1'b1;
            if (length != 16'd0) begin
               if (!head_done) begin
                  if (leads_digit) begin
                     restart_entry();
                     expect_word(atqet_pkg::END_MARK);
                     return;
                  end
                  for (int k = 0; k < atqet_pkg::KW_COUNT; k++) begin
                     if (kw_alive[k] && (int'(kw_idx) == keyword_len(k))) begin
                        closes_on_string = 1'b1;
                     end
                  end
                  head_done = 1'b1;
               end
               absorb_byte(atqet_pkg::CH_SPACE);
               expect_word(byte_word(atqet_pkg::CH_SPACE));
            end
            return;
         end
         if (b == atqet_pkg::CH_SEMI) begin
            restart_entry();
            expect_word(atqet_pkg::END_MARK);
            return;
         end
         space_seen = 1'b0;
         absorb_byte(b);
         if (b == atqet_pkg::CH_AT) begin
            str_phase = atqet_pkg::PH_STRING;
         end
         expect_word(byte_word(b));
      endfunction

      function void note_request(atqet_pkg::req_type w);
         logic [7:0] b;
         b = w.data_byte;
         if (w.mode == MODE_EOF) begin
            restart_entry();
            expect_word(atqet_pkg::END_MARK);
            return;
         end
         case (str_phase)
            atqet_pkg::PH_STRING: begin
               if (b == atqet_pkg::CH_AT) begin
                  absorb_byte(b);
                  str_phase = atqet_pkg::PH_AT_SEEN;
                  expect_word(byte_word(b));
               end else if (bump(length) > limit) begin
                  restart_entry();
                  expect_word(atqet_pkg::TOO_LONG_MARK);
               end else begin
                  absorb_byte(b);
                  expect_word(byte_word(b));
               end
            end
            atqet_pkg::PH_AT_SEEN: begin
               if (b == atqet_pkg::CH_AT) begin
                  absorb_byte(b);
                  str_phase = atqet_pkg::PH_STRING;
                  expect_word(byte_word(b));
               end else begin
                  // lone '@' closed the string; a keyword entry ends here
                  str_phase = atqet_pkg::PH_OUTSIDE;
                  if (closes_on_string) begin
                     restart_entry();
                     expect_word(atqet_pkg::END_MARK);
                  end
                  lex_plain(b);
               end
            end
            default: lex_plain(b);
         endcase
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("mismatch %0d: %s", mismatches, what);
         end
      endtask

      task check_result(atqet_pkg::rsp_type got);
         atqet_pkg::rsp_type want;
         words_seen++;
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("word %0d arrived with nothing expected (%02h %b%b%b)",
               words_seen, got.out_byte, got.has_byte, got.end_of_entry, got.too_long));
            return;
         end
         want = expected_words.pop_front();
         if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("word %0d out_byte %02h, expected %02h",
               words_seen, got.out_byte, want.out_byte));
         if (got.has_byte !== want.has_byte)
            report_mismatch($sformatf("word %0d has_byte %b, expected %b",
               words_seen, got.has_byte, want.has_byte));
         if (got.end_of_entry !== want.end_of_entry)
            report_mismatch($sformatf("word %0d end_of_entry %b, expected %b",
               words_seen, got.end_of_entry, want.end_of_entry));
         if (got.too_long !== want.too_long)
            report_mismatch($sformatf("word %0d too_long %b, expected %b",
               words_seen, got.too_long, want.too_long));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the block
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   atqet_req_if req_if ();
   atqet_rsp_if rsp_if ();
   atqet_csr_if csr_if ();

   at_quoted_entry_tokenizer_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tokenizer_scoreboard board = new();

   int unsigned items_sent      = 0;
   bit          tx_steady       = 1'b0;  // sender offers back to back
   bit          rx_steady       = 1'b0;  // receiver always ready
   bit          rx_hold_request = 1'b0;  // ask the receiver for one long hold-off

   // -------------------------------------------------------------------------
   // Sender side
   // -------------------------------------------------------------------------

   // Offer one word after a random gap; hold it until the block takes it.
   task automatic send_word(input logic m, input logic [7:0] b);
      int                 gap;
      atqet_pkg::req_type w;
      gap = tx_steady ? 0 : int'($urandom_range(0, 10));
      repeat (gap) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.mode      <= m;
      req_if.data_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      w.mode      = m;
      w.data_byte = b;
      board.note_request(w);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_word(MODE_DATA, b);
   endtask

   // Drop valid, let every expected word drain, then allow for bytes that
   // made no result but may still be inside the pipeline.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the length limit; call only while the block is idle.
   task automatic write_limit(input logic [15:0] v);
      csr_if.valid <= 1'b1;
      csr_if.wdata <= v;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      board.limit = v;
   endtask

   // -------------------------------------------------------------------------
   // Stimulus pieces
   // -------------------------------------------------------------------------
   function automatic int string_size();
      return ($urandom_range(0, 5) == 0) ? int'($urandom_range(13, 50))
                                         : int'($urandom_range(0, 12));
   endfunction

   task automatic send_whitespace();
      int n;
      n = $urandom_range(1, 3);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0:       send_byte(atqet_pkg::CH_SPACE);
            1:       send_byte(atqet_pkg::CH_TAB);
            2:       send_byte(atqet_pkg::CH_CR);
            default: send_byte(atqet_pkg::CH_LF);
         endcase
      end
   endtask

   task automatic send_bare_word();
      int n;
      n = $urandom_range(1, 6);
      repeat (n) send_byte(8'($urandom_range(8'h61, 8'h7A)));
   endtask

   // '@', n random bytes with every '@' doubled, and the closing '@' if asked
   task automatic send_quoted(input int n, input bit closed);
      logic [7:0] b;
      send_byte(atqet_pkg::CH_AT);
      repeat (n) begin
         b = ($urandom_range(0, 7) == 0) ? atqet_pkg::CH_AT : 8'($urandom_range(0, 255));
         send_byte(b);
         if (b == atqet_pkg::CH_AT) send_byte(atqet_pkg::CH_AT);
      end
      if (closed) send_byte(atqet_pkg::CH_AT);
   endtask

   // desc/log/text followed by a string; a few are misspelt or left open
   task automatic send_keyword_entry();
      logic [31:0] spelled;
      int          len;
      int          flaw;
      flaw = $urandom_range(0, 9);
      case (int'($urandom_range(0, 2)))
         KEY_DESC: begin
            spelled = "desc";
            len     = 4;
         end
         KEY_LOG: begin
            spelled = {"log", 8'h00};
            len     = 3;
         end
         default: begin
            spelled = "text";
            len     = 4;
         end
      endcase
      if (flaw == 0) len = len - 1;          // drop the last letter
      for (int i = 0; i < len; i++) send_byte(spelled[8*(3-i) +: 8]);
      if (flaw == 1) send_byte("s");         // one letter too many
      if (flaw != 2) send_whitespace();      // else join the string straight on
      send_quoted(string_size(), flaw != 3);
   endtask

   // revision-style number ended by whitespace, now and then by ';'
   task automatic send_number_entry();
      int n;
      if ($urandom_range(0, 3) == 0) send_whitespace();
      n = $urandom_range(1, 4);
      repeat (n) begin
         send_byte(8'($urandom_range(atqet_pkg::CH_ZERO, atqet_pkg::CH_NINE)));
         if ($urandom_range(0, 3) == 0) send_byte(".");
      end
      if ($urandom_range(0, 4) == 0) send_byte(atqet_pkg::CH_SEMI);
      else send_whitespace();
   endtask

   // words and strings ended by ';'
   task automatic send_general_entry();
      int parts;
      if ($urandom_range(0, 2) == 0) send_whitespace();
      if ($urandom_range(0, 3) == 0) send_quoted(string_size(), 1'b1);
      else send_bare_word();
      parts = $urandom_range(0, 2);
      repeat (parts) begin
         send_whitespace();
         if ($urandom_range(0, 1) == 0) send_bare_word();
         else send_quoted(string_size(), $urandom_range(0, 9) != 0);
      end
      if ($urandom_range(0, 1) == 0) send_whitespace();
      send_byte(atqet_pkg::CH_SEMI);
   endtask

   task automatic send_random_entry();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         send_keyword_entry();
      end else if (pick < 42) begin
         send_number_entry();
      end else if (pick < 75) begin
         send_general_entry();
      end else if (pick < 92) begin
         // raw noise over the whole byte range
         n = $urandom_range(1, 6);
         repeat (n) send_byte(8'($urandom_range(0, 255)));
      end else begin
         send_word(MODE_EOF, 8'($urandom_range(0, 255)));
      end
   endtask

   // Short hand-written stream: leading whitespace dropped, a keyword string
   // with a doubled '@' whose closing '@' ends the entry and hands the next
   // byte to a new one, ';' on an empty entry, a numeric first word, byte
   // extremes, end of input inside an open string and on an empty entry,
   // then a too-long abort at the lowest limit.
   task automatic run_directed();
      string script;
      script = " \tlog\r@a@@@x\n;;7 ";
      for (int i = 0; i < script.len(); i++) send_byte(script[i]);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(atqet_pkg::CH_AT);
      send_word(MODE_EOF, 8'h00);
      send_word(MODE_EOF, 8'hFF);
      settle();
      write_limit(16'd1);
      send_byte(atqet_pkg::CH_AT);
      send_byte("q");
   endtask

   task automatic run_phase(input logic [15:0] lim, input bit tx, input bit rx,
                            input bit hold, input int count);
      int unsigned stop;
      settle();
      write_limit(lim);
      tx_steady       = tx;
      rx_steady       = rx;
      rx_hold_request = hold;
      stop = items_sent + count;
      while (items_sent < stop) send_random_entry();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : main_sequence
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.mode      <= MODE_DATA;
      req_if.data_byte <= 8'h00;
      csr_if.valid     <= 1'b0;
      csr_if.wdata     <= 16'd0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // limit, steady sender, steady receiver, long hold-off, items
      run_phase(16'd65534,                        1'b0, 1'b0, 1'b0, 140);
      run_phase(16'($urandom_range(4, 24)),       1'b0, 1'b1, 1'b0, 120);
      run_phase(atqet_pkg::MAX_LEN_RESET,         1'b1, 1'b0, 1'b1, 120);
      run_phase(16'd1,                            1'b0, 1'b0, 1'b0, 100);
      run_phase(16'($urandom_range(25, 80)),      1'b1, 1'b1, 1'b0, 120);
      settle();

      if (board.pending() != 0)
         board.report_mismatch($sformatf("%0d expected words never arrived",
                                         board.pending()));
      if (board.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver: random stalls per word, one long hold-off on request
   // -------------------------------------------------------------------------
   initial begin : result_sink
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rx_steady ? 0 : int'($urandom_range(0, 10));
         if (rx_hold_request) begin
            // hold off while the sender keeps offering, so the queue fills
            stall           = RX_HOLD_CYCLES;
            rx_hold_request = 1'b0;
         end
         repeat (stall) begin
            rsp_if.ready <= 1'b0;
            @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // Check every accepted result word against the oldest prediction.
   always @(posedge clock) begin : result_monitor
      atqet_pkg::rsp_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.out_byte     = rsp_if.out_byte;
         got.has_byte     = rsp_if.has_byte;
         got.end_of_entry = rsp_if.end_of_entry;
         got.too_long     = rsp_if.too_long;
         board.check_result(got);
      end
   end

   // Advance an idle count on every cycle with no handshake; stop on a hang.
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) ||
             (rsp_if.valid && rsp_if.ready) || (csr_if.valid && csr_if.ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: files.f
hdl/atqet_pkg.sv
hdl/atqet_if.sv
hdl/atqet_lexer.sv
hdl/atqet_rsp_fifo.sv
hdl/at_quoted_entry_tokenizer_core.sv
verif/at_quoted_entry_tokenizer_core_tb.sv
